[sv/spu_pkg.sv]
// ----------------------------------------------------------------------------
// spu_pkg
// shared types and constants for the septet pack/unpack unit
// ----------------------------------------------------------------------------
package spu_pkg;

    localparam logic       MODE_PACK    = 1'b0;
    localparam logic       MODE_UNPACK  = 1'b1;
    localparam logic [7:0] SEPTET_MASK  = 8'h7f;
    localparam logic [2:0] UNPACK_LAST  = 3'd6;   // phase of the seventh octet
    localparam logic [2:0] UNPACK_GROUP = 3'd7;

    // results of one input item, queued between front and back
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic       two;      // item gives two results
        logic       eom;      // item ends the message
    } spu_entry_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } spu_q_status_t;

endpackage

[sv/spu_front.sv]
// ----------------------------------------------------------------------------
// spu_front
// accepts input items, keeps phase and carry, forms the results of each item
// ----------------------------------------------------------------------------
module spu_front
    import spu_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          mode,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    in_data,
    input  logic          in_eom,
    input  spu_q_status_t q_status,
    output logic          push,
    output spu_entry_t    push_entry
);

    logic [2:0] phase_reg, phase_next;
    logic [7:0] carry_reg, carry_next;

    logic       accept;
    logic [7:0] chr;
    logic [7:0] pk_word;
    logic [7:0] pk_carry;
    logic [2:0] pk_phase;
    logic       pk_flush;
    logic [2:0] un_shift;
    logic [7:0] un_word;
    logic [7:0] un_carry;
    logic       un_done;
    logic       has_result;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        chr      = in_data & SEPTET_MASK;
        pk_word  = chr << (4'd8 - {1'b0, phase_reg});
        pk_word  = pk_word | carry_reg;
        pk_carry = (phase_reg == 3'd0) ? chr : (chr >> phase_reg);
        pk_phase = phase_reg + 3'd1;
        pk_flush = in_eom && (pk_phase != 3'd0);

        un_shift = (phase_reg < UNPACK_GROUP) ? (UNPACK_GROUP - phase_reg) : 3'd0;
        un_word  = ((in_data << phase_reg) | carry_reg) & SEPTET_MASK;
        un_carry = in_data >> un_shift;
        un_done  = (phase_reg >= UNPACK_LAST);

        push_entry = '0;
        has_result = 1'b0;
        phase_next = phase_reg;
        carry_next = carry_reg;

        unique case (mode)
            MODE_PACK:
            begin
                if (phase_reg == 3'd0)
                begin
                    push_entry.byte0 = pk_carry;
                    push_entry.two   = 1'b0;
                    has_result       = pk_flush;
                end
                else
                begin
                    push_entry.byte0 = pk_word;
                    push_entry.byte1 = pk_carry;
                    push_entry.two   = pk_flush;
                    has_result       = 1'b1;
                end
                phase_next = pk_phase;
                carry_next = pk_flush ? 8'd0 : pk_carry;
            end
            MODE_UNPACK:
            begin
                push_entry.byte0 = un_word;
                push_entry.byte1 = un_carry & SEPTET_MASK;
                push_entry.two   = un_done;
                has_result       = 1'b1;
                phase_next       = un_done ? 3'd0 : phase_reg + 3'd1;
                carry_next       = un_done ? 8'd0 : un_carry;
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase

        push_entry.eom = in_eom;
        if (in_eom)
        begin
            phase_next = 3'd0;
            carry_next = 8'd0;
        end
    end

    assign push = accept && has_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 3'd0;
            carry_reg <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

    a_eom_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_eom) |=> (phase_reg == 3'd0 && carry_reg == 8'd0))
        else $error("state not cleared after message end");

    a_pack_carry_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && mode == MODE_PACK) |=> !carry_reg[7])
        else $error("pack carry holds more than seven bits");

endmodule

[sv/spu_fifo.sv]
// ----------------------------------------------------------------------------
// spu_fifo
// short queue of per-item results between front and back
// ----------------------------------------------------------------------------
module spu_fifo
    import spu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  spu_entry_t    push_entry,
    input  logic          pop,
    output spu_entry_t    head,
    output spu_q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    spu_entry_t             entries_reg [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("push into full queue");

endmodule

[sv/spu_back.sv]
// ----------------------------------------------------------------------------
// spu_back
// sends the one or two results of each queued item on the output stream
// ----------------------------------------------------------------------------
module spu_back
    import spu_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  spu_entry_t    head,
    input  spu_q_status_t q_status,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          run_last,
    output logic          message_last
);

    logic sub_reg, sub_next;
    logic fire;

    assign out_valid    = !q_status.empty;
    assign out_byte     = sub_reg ? head.byte1 : head.byte0;
    assign run_last     = sub_reg || !head.two;
    assign message_last = run_last && head.eom;
    assign fire         = out_valid && out_ready;
    assign pop          = fire && run_last;

    always_comb
    begin
        sub_next = sub_reg;
        if (fire)
        begin
            sub_next = !run_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_reg <= 1'b0;
        end
        else
        begin
            sub_reg <= sub_next;
        end
    end

    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !run_last) |=> (sub_reg && out_valid))
        else $error("second result of item lost");

endmodule

[sv/septet_pack_unpack_unit.sv]
// ----------------------------------------------------------------------------
// septet_pack_unpack_unit
// gsm 7-bit septet packing (mode 0) and unpacking (mode 1) on a byte stream
// ----------------------------------------------------------------------------
// The unit takes one input item per cycle while its queue has room; an item
// gives zero, one or two results, which leave on the single output port at
// one per cycle while the receiver is ready. A queue of QUEUE_DEPTH items
// between the input stage and the output stage absorbs two-result items and
// any output stall. s_tlast ends a message: pending carry bits are flushed in
// pack mode and the phase and carry return to zero. The user must write the
// mode register via cfg_we/cfg_data only while the unit is idle; unenforced.
module septet_pack_unpack_unit
    import spu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_data,     // direction_mode
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,      // [7:0] data_byte
    input  logic       s_tlast,      // end_of_message
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,      // [7:0] out_byte
    output logic       m_tuser,      // run_last
    output logic       m_tlast       // message_last
);

    logic          mode_reg, mode_next;
    logic          push;
    logic          pop;
    spu_entry_t    push_entry;
    spu_entry_t    head;
    spu_q_status_t q_status;

    always_comb
    begin
        mode_next = cfg_we ? cfg_data : mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PACK;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    spu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (mode_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .in_eom     (s_tlast),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    spu_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    spu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_status     (q_status),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_byte     (m_tdata),
        .run_last     (m_tuser),
        .message_last (m_tlast)
    );

    a_msg_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> m_tuser)
        else $error("message end not on last result of item");

endmodule

[dv/spu_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spu_checker
// watches both streams of the septet pack/unpack unit, predicts every result
// ----------------------------------------------------------------------------
// Tracks the mode register from cfg writes and keeps its own phase and carry.
// Each accepted input item is run through the septet predictor and its
// results are queued; each accepted output result is compared field by field
// against the oldest queued one. Mismatches and unexpected results are
// counted; the count and the number of results still owed go to the top.
module spu_checker
    import spu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_data,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tuser,
    input  logic       m_tlast,
    output int         mismatch_count,
    output int         results_owed
);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       message_last;
    } septet_result_t;

    septet_result_t expected_results[$];
    septet_result_t got;
    septet_result_t want;

    logic       mode;
    logic [2:0] phase;
    logic [7:0] carry;

    task automatic predict_septets(input logic [7:0] b, input logic eom);
        septet_result_t res [2];
        logic [15:0]    wide;
        logic [3:0]     ph;
        int             n;
        n  = 0;
        ph = {1'b0, phase};
        if (mode == MODE_PACK)
        begin
            if (ph == 4'd0)
            begin
                carry = b & SEPTET_MASK;
            end
            else
            begin
                wide = {8'b0, b & SEPTET_MASK} << (4'd8 - ph);
                res[n] = '{wide[7:0] | carry, 1'b0, 1'b0};
                n++;
                carry = (b & SEPTET_MASK) >> ph;
            end
            ph = (ph + 4'd1) & 4'd7;
            // pending carry goes out as if a zero character followed
            if (eom && ph != 4'd0)
            begin
                res[n] = '{carry, 1'b0, 1'b0};
                n++;
                carry = 8'd0;
            end
        end
        else
        begin
            wide = {8'b0, b} << ph;
            res[n] = '{(wide[7:0] | carry) & SEPTET_MASK, 1'b0, 1'b0};
            n++;
            carry = (ph < UNPACK_GROUP) ? (b >> (4'd7 - ph)) : b;
            ph = ph + 4'd1;
            if (ph >= UNPACK_GROUP)
            begin
                res[n] = '{carry & SEPTET_MASK, 1'b0, 1'b0};
                n++;
                ph    = 4'd0;
                carry = 8'd0;
            end
        end
        phase = ph[2:0];
        if (n > 0)
        begin
            res[n-1].run_last     = 1'b1;
            res[n-1].message_last = eom;
        end
        for (int i = 0; i < n; i++)
            expected_results.push_back(res[i]);
        if (eom)
        begin
            phase = 3'd0;
            carry = 8'd0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode  = MODE_PACK;
            phase = 3'd0;
            carry = 8'd0;
            expected_results.delete();
            mismatch_count = 0;
            results_owed   = 0;
        end
        else
        begin
            if (cfg_we)
                mode = cfg_data;
            if (s_tvalid && s_tready)
                predict_septets(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                got = '{m_tdata, m_tuser, m_tlast};
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result %02h/%0b/%0b",
                                 $time, got.out_byte, got.run_last, got.message_last);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: mismatch expected %02h/%0b/%0b got %02h/%0b/%0b",
                                     $time, want.out_byte, want.run_last,
                                     want.message_last, got.out_byte, got.run_last,
                                     got.message_last);
                    end
                end
            end
            results_owed = expected_results.size();
        end
    end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the septet pack/unpack unit
// ----------------------------------------------------------------------------
// A directed opening covers field extremes, flush and no-flush message ends,
// the ignored character high bit, a full unpack group and a mode change in
// the middle of a group. Random messages follow in both modes under three
// idling profiles, with unfinished messages carried across mode changes, a
// long output stall and a full drain pause. Checking is done by spu_checker.
module testbench
    import spu_pkg::*;
();

    localparam int SEGMENT_ITEMS = 320;
    localparam int DRAIN_CYCLES  = 20;
    localparam int STALL_CYCLES  = 400;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_data;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    int mismatch_count;
    int results_owed;
    int send_idle_pct;
    int take_idle_pct;
    int stall_requests;

    septet_pack_unpack_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    spu_checker result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always #5 clk = ~clk;

    // one item, with random idle cycles ahead of it
    task automatic send_item(input logic [7:0] d, input logic eom);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= eom;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic send_message(input int len, input logic close);
        for (int i = 0; i < len; i++)
            send_item(8'($urandom_range(255)), close && (i == len - 1));
    endtask

    // every result out, then room for an item still in flight with none
    task automatic settle();
        s_tvalid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input logic m);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(negedge clk);
        cfg_we   <= 1'b0;
        @(negedge clk);
    endtask

    // receiver
    initial
    begin
        int stalls_served;
        m_tready      = 1'b0;
        stalls_served = 0;
        forever
        begin
            @(negedge clk);
            if (stall_requests != stalls_served)
            begin
                stalls_served++;
                m_tready <= 1'b0;
                for (int k = 0; k < STALL_CYCLES; k++)
                    @(negedge clk);
            end
            m_tready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        logic [7:0] full_group [8];
        logic [7:0] octet_group [7];
        int  len;
        int  sent;
        bit  paused;
        full_group  = '{8'h7f, 8'h00, 8'hff, 8'h55, 8'h2a, 8'h01, 8'h40, 8'h3f};
        octet_group = '{8'hff, 8'h00, 8'h80, 8'h01, 8'haa, 8'h55, 8'h7f};
        clk      = 1'b0;
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        s_tlast  = 1'b0;
        send_idle_pct  = 13;
        take_idle_pct  = 74;
        stall_requests = 0;
        paused         = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // pack: single character flush, high bit ignored, group of eight ends clean
        write_mode(MODE_PACK);
        send_item(8'hff, 1'b1);
        send_item(8'h80, 1'b0);
        send_item(8'h7f, 1'b1);
        for (int i = 0; i < 8; i++)
            send_item(full_group[i], i == 7);
        // seven characters left open, then unpack picks up at phase seven
        for (int i = 0; i < 7; i++)
            send_item(full_group[i] ^ 8'h2d, 1'b0);
        write_mode(MODE_UNPACK);
        send_item(8'hff, 1'b1);
        for (int i = 0; i < 7; i++)
            send_item(octet_group[i], i == 6);

        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct = (p == 0) ? 13 : (p == 1) ? 74 : 0;
            take_idle_pct = (p == 0) ? 74 : (p == 1) ? 13 : 0;
            for (int m = 0; m < 2; m++)
            begin
                write_mode(m == 0 ? MODE_PACK : MODE_UNPACK);
                if (p == 1 && m == 0)
                    stall_requests++;
                sent = 0;
                while (sent < SEGMENT_ITEMS)
                begin
                    if (p == 2 && !paused && sent > 100)
                    begin
                        settle();
                        paused = 1'b1;
                    end
                    len = ($urandom_range(9) == 0) ? $urandom_range(60, 20)
                                                   : $urandom_range(16, 1);
                    send_message(len, 1'b1);
                    sent += len;
                end
                // unfinished message runs into the next mode
                if ($urandom_range(1) == 1)
                    send_message($urandom_range(12, 1), 1'b0);
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
